// ===== sv/assert_macros.svh =====
// Assertion helpers, included by the stack engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/lse_pkg.sv =====
package lse_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    typedef logic signed [WORD_W-1:0] lse_word_t;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_LIST = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
    localparam logic [OP_W-1:0] OP_POP  = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADARG    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PEEKEMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POPEMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SWAPSHORT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // Cell load selects
    typedef logic [1:0] lse_sel_t;
    localparam lse_sel_t SEL_HOLD = 2'd0;
    localparam lse_sel_t SEL_UP   = 2'd1;  // take the cell below (toward bottom)
    localparam lse_sel_t SEL_DOWN = 2'd2;  // take the cell above (toward top)
    localparam lse_sel_t SEL_WRAP = 2'd3;  // take the top cell

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        lse_word_t       push_value;
        logic            arg_ok;
    } lse_cmd_t;

    typedef struct packed {
        lse_word_t           data;
        logic                has_data;
        logic [STATUS_W-1:0] status;
        logic                last;
    } lse_rsp_t;

endpackage

// ===== sv/lse_cell.sv =====
module lse_cell
(
    input  logic              clk,
    input  lse_pkg::lse_sel_t sel,
    input  lse_pkg::lse_word_t above,
    input  lse_pkg::lse_word_t below,
    input  lse_pkg::lse_word_t top,
    output lse_pkg::lse_word_t q
);

    lse_pkg::lse_word_t word_reg;
    lse_pkg::lse_word_t word_next;

    always_comb
    begin
        case (sel)
            lse_pkg::SEL_UP:   word_next = below;
            lse_pkg::SEL_DOWN: word_next = above;
            lse_pkg::SEL_WRAP: word_next = top;
            default:           word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

// ===== sv/lse_out_buf.sv =====
module lse_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lse_pkg::lse_rsp_t din,
    output logic              full,
    output logic              valid,
    input  logic              stall,
    output lse_pkg::lse_rsp_t dout
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    lse_pkg::lse_rsp_t out_reg;
    lse_pkg::lse_rsp_t out_next;
    lse_pkg::lse_rsp_t skid_reg;
    lse_pkg::lse_rsp_t skid_next;
    logic              out_free;

    // Output slot can take a word when empty or being drained this cycle.
    assign out_free = !out_valid_reg || !stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = din;
                out_valid_next = load;
            end
        end
        else if (load)
        begin
            skid_next       = din;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign dout  = out_reg;

endmodule

// ===== sv/lifo_stack_engine.sv =====
// Bounded LIFO stack of signed 32-bit words built as a chain of DEPTH cells,
// cell 0 holding the top entry. Push shifts the chain toward the bottom and
// loads the new word into cell 0; pop shifts it toward the top; swap trades
// cells 0 and 1; peek reads cell 0. Each of these, and any unknown opcode,
// yields one result word. List-all on an empty stack yields one word; on n
// stored entries, after the accept the occupied part of the chain rotates
// by one cell per cycle while the output buffer is not full, cell 0
// feeding the result and wrapping into the bottom occupied cell, so after n
// steps the stack is back in place. Results pass through a two-word output
// buffer, so the command side keeps going while one result waits; commands
// stall during a listing and while that buffer is full. Errors leave the
// stack unchanged and are reported in the status field.
`include "assert_macros.svh"

module lifo_stack_engine
#(
    parameter int DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  lse_pkg::lse_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output lse_pkg::lse_rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Entry count and listing sequencer
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             list_active_reg;
    logic             list_active_next;
    logic [CNT_W-1:0] list_left_reg;
    logic [CNT_W-1:0] list_left_next;

    logic             cmd_acc;
    logic             buf_full;
    logic             list_step;
    logic             is_empty;
    logic             is_full;
    logic             push_ok;
    logic             pop_ok;
    logic             swap_ok;
    logic [CNT_W-1:0] count_m1;

    logic              rsp_load;
    lse_pkg::lse_rsp_t rsp_word;

    lse_pkg::lse_word_t cell_q   [DEPTH];
    lse_pkg::lse_sel_t  cell_sel [DEPTH];

    assign cmd_stall = list_active_reg || buf_full;
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign list_step = list_active_reg && !buf_full;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign count_m1 = count_reg - 1'b1;
    assign push_ok  = cmd.arg_ok && !is_full;
    assign pop_ok   = !is_empty;
    assign swap_ok  = (count_reg >= CNT_W'(2));

    // Count and listing state
    always_comb
    begin
        count_next       = count_reg;
        list_active_next = list_active_reg;
        list_left_next   = list_left_reg;
        if (list_step)
        begin
            list_left_next = list_left_reg - 1'b1;
            if (list_left_reg == CNT_W'(1))
            begin
                list_active_next = 1'b0;
            end
        end
        else if (cmd_acc)
        begin
            case (cmd.opcode)
                lse_pkg::OP_PUSH:
                begin
                    if (push_ok)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                lse_pkg::OP_POP:
                begin
                    if (pop_ok)
                    begin
                        count_next = count_m1;
                    end
                end
                lse_pkg::OP_LIST:
                begin
                    if (!is_empty)
                    begin
                        list_active_next = 1'b1;
                        list_left_next   = count_reg;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            list_active_reg <= 1'b0;
            list_left_reg   <= '0;
        end
        else
        begin
            count_reg       <= count_next;
            list_active_reg <= list_active_next;
            list_left_reg   <= list_left_next;
        end
    end

    // Result word: one per accepted command except a non-empty list, whose
    // words come from the listing steps.
    always_comb
    begin
        rsp_word          = '0;
        rsp_word.last     = 1'b1;
        rsp_word.status   = lse_pkg::ST_OK;
        rsp_load          = 1'b0;
        if (list_step)
        begin
            rsp_load          = 1'b1;
            rsp_word.data     = cell_q[0];
            rsp_word.has_data = 1'b1;
            rsp_word.last     = (list_left_reg == CNT_W'(1));
        end
        else if (cmd_acc)
        begin
            rsp_load = 1'b1;
            case (cmd.opcode)
                lse_pkg::OP_PUSH:
                begin
                    if (!cmd.arg_ok)
                    begin
                        rsp_word.status = lse_pkg::ST_BADARG;
                    end
                    else if (is_full)
                    begin
                        rsp_word.status = lse_pkg::ST_FULL;
                    end
                end
                lse_pkg::OP_LIST:
                begin
                    // Empty stack: one marker word; otherwise the listing
                    // steps emit.
                    rsp_load = is_empty;
                end
                lse_pkg::OP_PEEK:
                begin
                    if (is_empty)
                    begin
                        rsp_word.status = lse_pkg::ST_PEEKEMPTY;
                    end
                    else
                    begin
                        rsp_word.data     = cell_q[0];
                        rsp_word.has_data = 1'b1;
                    end
                end
                lse_pkg::OP_POP:
                begin
                    if (!pop_ok)
                    begin
                        rsp_word.status = lse_pkg::ST_POPEMPTY;
                    end
                end
                lse_pkg::OP_SWAP:
                begin
                    if (!swap_ok)
                    begin
                        rsp_word.status = lse_pkg::ST_SWAPSHORT;
                    end
                end
                default:
                begin
                    rsp_word.status = lse_pkg::ST_OK;
                end
            endcase
        end
    end

    // Cell chain: each cell picks its next word from its neighbors, the top cell or, for cell 0, the pushed value.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        lse_pkg::lse_word_t above;
        lse_pkg::lse_word_t below;

        if (i == 0)
        begin : g_top
            assign above = cmd.push_value;
        end
        else
        begin : g_mid
            assign above = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign below = '0;
        end
        else
        begin : g_inner
            assign below = cell_q[i+1];
        end

        always_comb
        begin
            cell_sel[i] = lse_pkg::SEL_HOLD;
            if (list_step)
            begin
                // Rotate the occupied cells one place toward the top.
                if (CNT_W'(i) == count_m1)
                begin
                    cell_sel[i] = lse_pkg::SEL_WRAP;
                end
                else if (CNT_W'(i) < count_m1)
                begin
                    cell_sel[i] = lse_pkg::SEL_UP;
                end
            end
            else if (cmd_acc)
            begin
                case (cmd.opcode)
                    lse_pkg::OP_PUSH:
                    begin
                        if (push_ok)
                        begin
                            cell_sel[i] = lse_pkg::SEL_DOWN;
                        end
                    end
                    lse_pkg::OP_POP:
                    begin
                        if (pop_ok)
                        begin
                            cell_sel[i] = lse_pkg::SEL_UP;
                        end
                    end
                    lse_pkg::OP_SWAP:
                    begin
                        if (swap_ok && i == 0)
                        begin
                            cell_sel[i] = lse_pkg::SEL_UP;
                        end
                        else if (swap_ok && i == 1)
                        begin
                            cell_sel[i] = lse_pkg::SEL_DOWN;
                        end
                    end
                    default:
                    begin
                        cell_sel[i] = lse_pkg::SEL_HOLD;
                    end
                endcase
            end
        end

        lse_cell u_cell
        (
            .clk   (clk),
            .sel   (cell_sel[i]),
            .above (above),
            .below (below),
            .top   (cell_q[0]),
            .q     (cell_q[i])
        );
    end

    lse_out_buf u_out_buf
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (rsp_load),
        .din   (rsp_word),
        .full  (buf_full),
        .valid (rsp_valid),
        .stall (rsp_stall),
        .dout  (rsp)
    );

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `ASSERT_IMPLY(a_list_left, clk, rst_n, list_active_reg, list_left_reg != '0)
    `ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, buf_full, rsp_valid)
    `ASSERT_NEXT(a_push_count, clk, rst_n,
                 cmd_acc && cmd.opcode == lse_pkg::OP_PUSH && push_ok,
                 count_reg == $past(count_reg) + 1'b1)

endmodule
